/* rtl/core/wbss_pkg.sv */
// shared types and constants of the wildcard byte signature scanner
`default_nettype none

package wbss_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int SIG_BYTES       = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_W           = 6;
    localparam int REPORT_W        = 32;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = 2;
    localparam int FIFO_CNT_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_A  = 3'd0,
        REG_PATTERN_B  = 3'd1,
        REG_PATTERN_C  = 3'd2,
        REG_PATTERN_D  = 3'd3,
        REG_CARE_MASK  = 3'd4,
        REG_LENGTH     = 3'd5,
        REG_FIRST_ONLY = 3'd6
    } cfg_reg_t;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                result_kind;
        logic [REPORT_W-1:0] match_offset;
        logic [REPORT_W-1:0] match_count;
        logic                run_end;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/wbss_config.sv */
// configuration registers and end-aligned signature for the window compare
`default_nettype none

module wbss_config #(
    parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN_DEF,
    parameter int LEN_CAP     = (MAX_PATTERN < wbss_pkg::SIG_BYTES) ?
                                MAX_PATTERN : wbss_pkg::SIG_BYTES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [LEN_CAP*8-1:0]                 sig_aligned,
    output logic [LEN_CAP-1:0]                   care_aligned,
    output logic [wbss_pkg::LEN_W-1:0]           eff_length,
    output logic                                 first_only,
    output logic                                 cfg_settle
);
    import wbss_pkg::*;

    localparam int SH_W = $clog2(LEN_CAP);

    logic [SIG_BYTES*8-1:0] pattern_reg;
    logic [SIG_BYTES-1:0]   care_reg;
    logic [LEN_W-1:0]       length_reg;
    logic                   first_reg;
    logic                   settle_reg;
    logic [LEN_CAP*8-1:0]   sig_al_reg, sig_al_next;
    logic [LEN_CAP-1:0]     care_al_reg, care_al_next;
    logic [LEN_W-1:0]       n_reg, n_next;
    logic [LEN_CAP*8-1:0]   sig_rev;
    logic [LEN_CAP-1:0]     care_rev;
    logic [SH_W-1:0]        shamt;
    logic                   cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            care_reg    <= '0;
            length_reg  <= LEN_W'(1);
            first_reg   <= 1'b0;
            settle_reg  <= 1'b1;
        end else begin
            settle_reg <= cfg_xfer;
            if (cfg_xfer) begin
                case (cfg_index)
                    REG_PATTERN_A:  pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_B:  pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_C:  pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_PATTERN_D:  pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                    REG_CARE_MASK:  care_reg   <= cfg_data[SIG_BYTES-1:0];
                    REG_LENGTH:     length_reg <= cfg_data[LEN_W-1:0];
                    REG_FIRST_ONLY: first_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // clamp length, then reverse and shift so signature byte n-1-k lines up with window byte k
    always_comb begin
        if (length_reg == '0) begin
            n_next = LEN_W'(1);
        end else if (length_reg > LEN_W'(LEN_CAP)) begin
            n_next = LEN_W'(LEN_CAP);
        end else begin
            n_next = length_reg;
        end
        for (int k = 0; k < LEN_CAP; k++) begin
            sig_rev[8*k +: 8] = pattern_reg[8*(LEN_CAP-1-k) +: 8];
            care_rev[k]       = care_reg[LEN_CAP-1-k];
        end
        shamt        = SH_W'(LEN_W'(LEN_CAP) - n_next);
        sig_al_next  = sig_rev >> {shamt, 3'b000};
        care_al_next = care_rev >> shamt;
    end

    always_ff @(posedge aclk) begin
        sig_al_reg  <= sig_al_next;
        care_al_reg <= care_al_next;
        n_reg       <= n_next;
    end

    assign sig_aligned  = sig_al_reg;
    assign care_aligned = care_al_reg;
    assign eff_length   = n_reg;
    assign first_only   = first_reg;
    assign cfg_settle   = settle_reg;

endmodule

`default_nettype wire

/* rtl/core/wbss_match.sv */
// input register, byte window, match compare and scan state
`default_nettype none

module wbss_match #(
    parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbss_pkg::OFFSET_BITS_DEF,
    parameter int LEN_CAP     = (MAX_PATTERN < wbss_pkg::SIG_BYTES) ?
                                MAX_PATTERN : wbss_pkg::SIG_BYTES
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_data_byte,
    input  wire logic                        s_final_byte,
    input  wire logic [LEN_CAP*8-1:0]        sig_aligned,
    input  wire logic [LEN_CAP-1:0]          care_aligned,
    input  wire logic [wbss_pkg::LEN_W-1:0]  eff_length,
    input  wire logic                        first_only,
    input  wire logic                        cfg_settle,
    input  wire logic                        room_ok,
    output logic [1:0]                       push_cnt,
    output wbss_pkg::result_t                res_a,
    output wbss_pkg::result_t                res_b
);
    import wbss_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_final_reg;
    logic [MAX_PATTERN*8-1:0] window_reg, window_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [OFFSET_BITS-1:0]   pos_reg, start_pos;
    logic [REPORT_W-1:0]      hits_reg, hits_inc, hits_after;
    logic                     found_reg;
    logic [LEN_CAP-1:0]       byte_ok;
    logic                     window_hit, fill_ok, hit, proc_fire;

    assign proc_fire = in_valid_reg & room_ok & ~cfg_settle;
    assign s_ready   = ~in_valid_reg | proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
    end

    always_comb begin
        window_next = {window_reg[(MAX_PATTERN-1)*8-1:0], in_byte_reg};
        fill_next   = (fill_reg == FILL_W'(MAX_PATTERN)) ? fill_reg : fill_reg + FILL_W'(1);
        for (int k = 0; k < LEN_CAP; k++) begin
            byte_ok[k] = ~care_aligned[k] | (window_next[8*k +: 8] == sig_aligned[8*k +: 8]);
        end
        window_hit = &byte_ok;
        fill_ok    = CMP_W'(fill_next) >= CMP_W'(eff_length);
        hit        = window_hit & fill_ok & ~(first_only & found_reg);
        start_pos  = pos_reg + OFFSET_BITS'(1) - OFFSET_BITS'(eff_length);
        hits_inc   = (hits_reg == '1) ? hits_reg : hits_reg + REPORT_W'(1);
        hits_after = hit ? hits_inc : hits_reg;

        res_b.result_kind  = KIND_SUMMARY;
        res_b.match_offset = '0;
        res_b.match_count  = hits_after;
        res_b.run_end      = 1'b1;

        if (hit) begin
            res_a.result_kind  = KIND_MATCH;
            res_a.match_offset = REPORT_W'(start_pos);
            res_a.match_count  = hits_after;
            res_a.run_end      = ~in_final_reg;
        end else begin
            res_a = res_b;
        end

        if (!proc_fire) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = 2'(hit) + 2'(in_final_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            hits_reg  <= '0;
            found_reg <= 1'b0;
        end else if (proc_fire) begin
            if (in_final_reg) begin
                fill_reg  <= '0;
                pos_reg   <= '0;
                hits_reg  <= '0;
                found_reg <= 1'b0;
            end else begin
                fill_reg  <= fill_next;
                pos_reg   <= pos_reg + OFFSET_BITS'(1);
                hits_reg  <= hits_after;
                found_reg <= found_reg | hit;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wbss_out_fifo.sv */
// four-entry result queue taking up to two results per cycle
`default_nettype none

module wbss_out_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        push_cnt,
    input  wire wbss_pkg::result_t res_a,
    input  wire wbss_pkg::result_t res_b,
    output logic                   room_ok,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output wbss_pkg::result_t      m_result
);
    import wbss_pkg::*;

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    assign m_valid  = count_reg != '0;
    assign pop      = m_valid & m_ready;
    assign room_ok  = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign m_result = entry_reg[rptr_reg];

    always_comb begin
        count_next = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wptr_reg] <= res_a;
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wptr_reg + FIFO_PTR_W'(1)] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_reg + FIFO_PTR_W'(push_cnt);
            rptr_reg  <= rptr_reg + FIFO_PTR_W'(pop);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("result queue written without room");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[FIFO_PTR_W-1:0] == FIFO_PTR_W'(wptr_reg - rptr_reg))
        else $error("queue count out of step with pointers");

    a_pair_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt == 2'd2 |=> count_reg >= FIFO_CNT_W'(2))
        else $error("result pair lost");

endmodule

`default_nettype wire

/* rtl/core/wildcard_byte_signature_scan.sv */
// top level of the wildcard byte signature scanner
//
// bytes of a memory image arrive on the s_ channel, one per transfer, with
// s_final_byte on the last one. the newest bytes are held in a window and
// compared against the signature (bytes with a clear care bit are wildcards).
// each match (only the first of a run when first_only is set) gives a
// result on the m_ channel carrying its start offset; the final byte also
// gives a summary with the match count. configuration goes over the cfg_
// channel; the user must write it only while the scan is idle, and the
// block itself does not enforce this. throughput: one byte per cycle while
// the queue has room and no configuration write is settling, set by the
// single compare stage; an input giving two results writes both into the
// four-entry queue. a configuration write pauses processing while the
// aligned signature is rebuilt; the same pause follows reset.
// reset clears the scan state and queue and loads default configuration.
// when the receiver stalls the queue fills and s_ready drops once fewer
// than two free entries remain; no result is lost.
`default_nettype none

module wildcard_byte_signature_scan #(
    parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbss_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic                            s_final_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_result_kind,
    output logic [wbss_pkg::REPORT_W-1:0]        m_match_offset,
    output logic [wbss_pkg::REPORT_W-1:0]        m_match_count,
    output logic                                 m_run_end,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wbss_pkg::*;

    localparam int LEN_CAP = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

    logic [LEN_CAP*8-1:0] sig_aligned;
    logic [LEN_CAP-1:0]   care_aligned;
    logic [LEN_W-1:0]     eff_length;
    logic                 first_only;
    logic                 cfg_settle;
    logic                 room_ok;
    logic [1:0]           push_cnt;
    result_t              res_a, res_b, m_result;

    wbss_config #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_CAP     (LEN_CAP)
    ) u_config (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sig_aligned  (sig_aligned),
        .care_aligned (care_aligned),
        .eff_length   (eff_length),
        .first_only   (first_only),
        .cfg_settle   (cfg_settle)
    );

    wbss_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS),
        .LEN_CAP     (LEN_CAP)
    ) u_match (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .sig_aligned  (sig_aligned),
        .care_aligned (care_aligned),
        .eff_length   (eff_length),
        .first_only   (first_only),
        .cfg_settle   (cfg_settle),
        .room_ok      (room_ok),
        .push_cnt     (push_cnt),
        .res_a        (res_a),
        .res_b        (res_b)
    );

    wbss_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .res_a    (res_a),
        .res_b    (res_b),
        .room_ok  (room_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_result_kind  = m_result.result_kind;
    assign m_match_offset = m_result.match_offset;
    assign m_match_count  = m_result.match_count;
    assign m_run_end      = m_result.run_end;

endmodule

`default_nettype wire
